### hw/rtl/lfu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lfu_pkg
// shared types and constants of the lfu page replacement block
// ---------------------------------------------------------------------------
package lfu_pkg;

  // fixed field widths of the stream and register interfaces
  localparam int unsigned PAGE_W  = 16;
  localparam int unsigned SLOT_W  = 6;
  localparam int unsigned TOTAL_W = 32;
  localparam int unsigned CFG_W   = 7;
  localparam int unsigned ADDR_W  = 3;

  // register map
  localparam logic [ADDR_W-1:0] ADDR_FRAMES_IN_USE = 3'd0;
  localparam logic [CFG_W-1:0]  FRAMES_IN_USE_RST  = 7'd64;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // controller to datapath
  typedef struct packed {
    logic load;    // latch the reference and clear the scan trackers
    logic scan;    // step the frame scan
    logic commit;  // update the table and load the result register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;  // last active frame has been compared
    logic out_full;   // result register cannot take a new result
  } status_t;

endpackage

`default_nettype wire

### hw/rtl/lfu_page_replacement.sv
`timescale 1ns / 1ps
`default_nettype none
// a reference is latched on acceptance, the scan then compares the n active frames,
//   n being the active frame count (frames_in_use clamped to 1..FRAMES), and the
//   commit loads the result register; no new reference is taken until it is committed,
//   and the scan reads one frame per cycle through the page and use count ram read ports
// reset: all frames empty, totals zero, frames_in_use back to 64
// ---------------------------------------------------------------------------
// lfu_page_replacement
// fully associative page frame table with least frequently used replacement
// ---------------------------------------------------------------------------
module lfu_page_replacement #(
  parameter int unsigned FRAMES     = 64,
  parameter int unsigned PAGE_BITS  = 16,
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // page reference stream
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  input  wire logic [15:0]                  s_tdata,   // [15:0] page_number
  // result stream
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  output logic [87:0]                       m_tdata,   // [5:0] frame_slot, [6] evicted_valid,
                                                       // [22:7] evicted_page,
                                                       // [54:23] fault_total,
                                                       // [86:55] reference_total, [87] zero
  output logic                              m_tuser,   // [0] hit
  // register port
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [lfu_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import lfu_pkg::*;

  localparam int unsigned NW = $clog2(FRAMES + 1);

  logic [CFG_W-1:0]   frames_in_use;
  logic [8:0]         fiu_ext;
  logic [NW-1:0]      active_frames;
  logic [31:0]        page_in_ext;
  logic [PAGE_BITS-1:0] in_page;

  cmd_t               cmd;
  status_t            status;

  logic               out_hit;
  logic [SLOT_W-1:0]  out_slot;
  logic               out_evicted_valid;
  logic [PAGE_W-1:0]  out_evicted_page;
  logic [TOTAL_W-1:0] out_fault_total;
  logic [TOTAL_W-1:0] out_reference_total;

  // register port
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_FRAMES_IN_USE) ? 32'(frames_in_use) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= FRAMES_IN_USE_RST;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_FRAMES_IN_USE) begin
      frames_in_use <= pwdata[CFG_W-1:0];
    end
  end

  // zero acts as one, anything above the table size as the table size
  assign fiu_ext = 9'(frames_in_use);
  always_comb begin
    if (fiu_ext == '0) begin
      active_frames = NW'(1);
    end else if (fiu_ext > 9'(FRAMES)) begin
      active_frames = NW'(FRAMES);
    end else begin
      active_frames = NW'(fiu_ext);
    end
  end

  assign page_in_ext = 32'(s_tdata);
  assign in_page     = page_in_ext[PAGE_BITS-1:0];

  lfu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (cmd),
    .status   (status)
  );

  lfu_datapath #(
    .FRAMES     (FRAMES),
    .PAGE_BITS  (PAGE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .status              (status),
    .in_page             (in_page),
    .active_frames       (active_frames),
    .out_ready           (m_tready),
    .out_valid           (m_tvalid),
    .out_hit             (out_hit),
    .out_slot            (out_slot),
    .out_evicted_valid   (out_evicted_valid),
    .out_evicted_page    (out_evicted_page),
    .out_fault_total     (out_fault_total),
    .out_reference_total (out_reference_total)
  );

  assign m_tuser = out_hit;
  assign m_tdata = {1'b0, out_reference_total, out_fault_total, out_evicted_page,
                    out_evicted_valid, out_slot};

  // a reference starts a scan, so no second one is taken right after it
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("reference accepted while a scan was running");

  // faults never outnumber references
  a_totals_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> out_fault_total <= out_reference_total)
    else $error("fault total above reference total");

  // an eviction is always a fault
  a_evict_is_fault: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_evicted_valid |-> !out_hit)
    else $error("eviction reported on a hit");

  // the table is only updated once the result register can take the result
  a_commit_room: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !m_tvalid || m_tready)
    else $error("result overwritten before it was taken");

endmodule

`default_nettype wire

### hw/rtl/lfu_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lfu_ram
// generic simple dual port ram, one write and one registered read port
// ---------------------------------------------------------------------------
module lfu_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hw/rtl/lfu_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lfu_ctrl
// sequencer for one page reference: accept, scan the frames, commit
// ---------------------------------------------------------------------------
module lfu_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            s_tvalid,
  output logic                 s_tready,
  output lfu_pkg::cmd_t        cmd,
  input  wire lfu_pkg::status_t status
);
  import lfu_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_COMMIT = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  assign s_tready   = (state == ST_IDLE);
  assign cmd.load   = s_tvalid && s_tready;
  assign cmd.scan   = (state == ST_SCAN);
  assign cmd.commit = (state == ST_COMMIT) && !status.out_full;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.scan_done) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (!status.out_full) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/lfu_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lfu_datapath
// frame table, one-frame-per-cycle scan, table update and result register
// ---------------------------------------------------------------------------
module lfu_datapath #(
  parameter int unsigned FRAMES     = 64,
  parameter int unsigned PAGE_BITS  = 16,
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire lfu_pkg::cmd_t                        cmd,
  output lfu_pkg::status_t                          status,
  input  wire logic [PAGE_BITS-1:0]                 in_page,
  input  wire logic [$clog2(FRAMES+1)-1:0]          active_frames,
  input  wire logic                                 out_ready,
  output logic                                      out_valid,
  output logic                                      out_hit,
  output logic [lfu_pkg::SLOT_W-1:0]                out_slot,
  output logic                                      out_evicted_valid,
  output logic [lfu_pkg::PAGE_W-1:0]                out_evicted_page,
  output logic [lfu_pkg::TOTAL_W-1:0]               out_fault_total,
  output logic [lfu_pkg::TOTAL_W-1:0]               out_reference_total
);
  import lfu_pkg::*;

  localparam int unsigned IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned NW    = $clog2(FRAMES + 1);

  // scan position and pipeline of the registered ram read
  logic [PAGE_BITS-1:0]  page_q;
  logic [NW-1:0]         issue_cnt;
  logic                  cmp_v;
  logic [IDX_W-1:0]      cmp_idx;
  logic                  issuing;
  logic [IDX_W-1:0]      last_idx;

  // scan trackers
  logic                  hit_found;
  logic [IDX_W-1:0]      hit_slot;
  logic [COUNT_BITS-1:0] hit_cnt;
  logic                  empty_found;
  logic [IDX_W-1:0]      empty_slot;
  logic [COUNT_BITS-1:0] best_cnt;
  logic [IDX_W-1:0]      best_slot;
  logic [PAGE_BITS-1:0]  best_page;

  logic [FRAMES-1:0]     frame_valid;
  logic [TOTAL_W-1:0]    fault_cnt;
  logic [TOTAL_W-1:0]    ref_cnt;

  logic [PAGE_BITS-1:0]  rd_page;
  logic [COUNT_BITS-1:0] rd_cnt;
  logic                  cmp_valid_bit;
  logic                  cmp_match;

  logic [IDX_W-1:0]      wr_slot;
  logic [COUNT_BITS-1:0] wr_cnt;
  logic                  is_evict;
  logic [TOTAL_W-1:0]    fault_cnt_next;
  logic [TOTAL_W-1:0]    ref_cnt_next;
  logic [31:0]           slot_ext;
  logic [31:0]           page_ext;

  assign issuing   = cmd.scan && (issue_cnt < active_frames);
  assign last_idx  = IDX_W'(active_frames - NW'(1));

  assign status.scan_done = cmp_v && (cmp_idx == last_idx);
  assign status.out_full  = out_valid && !out_ready;

  lfu_ram #(
    .WIDTH (PAGE_BITS),
    .DEPTH (FRAMES)
  ) u_page_ram (
    .clk   (clk),
    .we    (cmd.commit && !hit_found),
    .waddr (wr_slot),
    .wdata (page_q),
    .raddr (issue_cnt[IDX_W-1:0]),
    .rdata (rd_page)
  );

  lfu_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (FRAMES)
  ) u_count_ram (
    .clk   (clk),
    .we    (cmd.commit),
    .waddr (wr_slot),
    .wdata (wr_cnt),
    .raddr (issue_cnt[IDX_W-1:0]),
    .rdata (rd_cnt)
  );

  assign cmp_valid_bit = frame_valid[cmp_idx];
  assign cmp_match     = cmp_valid_bit && (rd_page == page_q);

  // victim choice: hit frame, else first empty frame, else least used
  always_comb begin
    if (hit_found) begin
      wr_slot = hit_slot;
    end else if (empty_found) begin
      wr_slot = empty_slot;
    end else begin
      wr_slot = best_slot;
    end
  end

  assign is_evict = !hit_found && !empty_found;
  assign wr_cnt   = !hit_found ? COUNT_BITS'(1) :
                    (&hit_cnt) ? hit_cnt : hit_cnt + COUNT_BITS'(1);

  assign ref_cnt_next   = (ref_cnt == TOTAL_MAX) ? ref_cnt : ref_cnt + TOTAL_W'(1);
  assign fault_cnt_next = (hit_found || fault_cnt == TOTAL_MAX) ? fault_cnt
                                                               : fault_cnt + TOTAL_W'(1);
  assign slot_ext = 32'(wr_slot);
  assign page_ext = 32'(best_page);

  // scan control, table valid bits, totals and result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_v       <= 1'b0;
      frame_valid <= '0;
      fault_cnt   <= '0;
      ref_cnt     <= '0;
      out_valid   <= 1'b0;
    end else begin
      cmp_v <= issuing;
      if (cmd.commit) begin
        frame_valid[wr_slot] <= 1'b1;
        fault_cnt            <= fault_cnt_next;
        ref_cnt              <= ref_cnt_next;
        out_valid            <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // scan payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      page_q      <= in_page;
      issue_cnt   <= '0;
      hit_found   <= 1'b0;
      empty_found <= 1'b0;
    end else begin
      if (issuing) begin
        issue_cnt <= issue_cnt + NW'(1);
        cmp_idx   <= issue_cnt[IDX_W-1:0];
      end
      if (cmp_v) begin
        if (cmp_match && !hit_found) begin
          hit_found <= 1'b1;
          hit_slot  <= cmp_idx;
          hit_cnt   <= rd_cnt;
        end
        if (!cmp_valid_bit && !empty_found) begin
          empty_found <= 1'b1;
          empty_slot  <= cmp_idx;
        end
        // strict compare keeps the lowest index on a tie
        if (cmp_idx == '0 || rd_cnt < best_cnt) begin
          best_cnt  <= rd_cnt;
          best_slot <= cmp_idx;
          best_page <= rd_page;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_hit             <= hit_found;
      out_slot            <= slot_ext[SLOT_W-1:0];
      out_evicted_valid   <= is_evict;
      out_evicted_page    <= is_evict ? page_ext[PAGE_W-1:0] : '0;
      out_fault_total     <= fault_cnt_next;
      out_reference_total <= ref_cnt_next;
    end
  end

endmodule

`default_nettype wire

### bench/lfu_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lfu_checker
// watches the page reference, result and register channels, keeps its own
// copy of the frame table and compares every result against it
// ---------------------------------------------------------------------------
module lfu_checker #(
  parameter int unsigned FRAMES     = 64,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  input  logic [15:0]                   s_tdata,   // [15:0] page_number
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic [87:0]                   m_tdata,   // [5:0] frame_slot, [6] evicted_valid,
                                                   // [22:7] evicted_page,
                                                   // [54:23] fault_total,
                                                   // [86:55] reference_total
  input  logic                          m_tuser,   // [0] hit
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lfu_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  input  logic [31:0]                   prdata,
  input  logic                          pready,
  output int                            errors,
  output int                            outstanding
);
  import lfu_pkg::*;

  typedef struct packed {
    logic               hit;
    logic [SLOT_W-1:0]  frame_slot;
    logic               evicted_valid;
    logic [PAGE_W-1:0]  evicted_page;
    logic [TOTAL_W-1:0] fault_total;
    logic [TOTAL_W-1:0] reference_total;
  } frame_result_t;

  logic [PAGE_W-1:0]     frame_page [FRAMES];
  logic                  frame_valid [FRAMES];
  logic [COUNT_BITS-1:0] frame_uses [FRAMES];
  logic [TOTAL_W-1:0]    faults_seen;
  logic [TOTAL_W-1:0]    refs_seen;
  logic [CFG_W-1:0]      frames_cfg;
  frame_result_t         result_queue [$];
  frame_result_t         got;
  frame_result_t         want;

  initial errors = 0;
  initial outstanding = 0;

  task automatic flag_mismatch(input string what, input logic [63:0] got_v,
                               input logic [63:0] want_v);
    errors++;
    $display("%0t mismatch: %s got %0h want %0h", $time, what, got_v, want_v);
  endtask

  // one page reference against the table copy: lookup, then empty fill, then lfu victim
  task automatic resolve_reference(input logic [PAGE_W-1:0] page, output frame_result_t res);
    int                    active;
    int                    slot;
    bit                    found;
    bit                    empty;
    logic [COUNT_BITS-1:0] best;
    active = int'(frames_cfg);
    if (active == 0) active = 1;
    if (active > FRAMES) active = FRAMES;
    res = '0;
    found = 1'b0;
    empty = 1'b0;
    slot = 0;
    if (refs_seen != TOTAL_MAX) refs_seen++;
    for (int i = 0; i < active; i++) begin
      if (!found && frame_valid[i] && frame_page[i] == page) begin
        slot = i;
        found = 1'b1;
      end
    end
    if (found) begin
      res.hit = 1'b1;
      if (frame_uses[slot] != '1) frame_uses[slot]++;
    end else begin
      for (int i = 0; i < active; i++) begin
        if (!empty && !frame_valid[i]) begin
          slot = i;
          empty = 1'b1;
        end
      end
      if (!empty) begin
        best = frame_uses[0];
        slot = 0;
        for (int i = 1; i < active; i++) begin
          if (frame_uses[i] < best) begin
            best = frame_uses[i];
            slot = i;
          end
        end
        res.evicted_valid = 1'b1;
        res.evicted_page = frame_page[slot];
      end
      frame_page[slot] = page;
      frame_valid[slot] = 1'b1;
      frame_uses[slot] = COUNT_BITS'(1);
      if (faults_seen != TOTAL_MAX) faults_seen++;
    end
    res.frame_slot = SLOT_W'(slot);
    res.fault_total = faults_seen;
    res.reference_total = refs_seen;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < FRAMES; i++) begin
        frame_valid[i] = 1'b0;
        frame_uses[i] = '0;
        frame_page[i] = '0;
      end
      faults_seen = '0;
      refs_seen = '0;
      frames_cfg = FRAMES_IN_USE_RST;
      result_queue.delete();
    end else begin
      // results first: one accepted at this edge belongs to an older reference
      if (m_tvalid && m_tready) begin
        got.hit = m_tuser;
        got.frame_slot = m_tdata[5:0];
        got.evicted_valid = m_tdata[6];
        got.evicted_page = m_tdata[22:7];
        got.fault_total = m_tdata[54:23];
        got.reference_total = m_tdata[86:55];
        if (result_queue.size() == 0) begin
          flag_mismatch("result with nothing expected, slot", 64'(got.frame_slot), 64'd0);
        end else begin
          want = result_queue.pop_front();
          if (got.hit !== want.hit)
            flag_mismatch("hit", 64'(got.hit), 64'(want.hit));
          if (got.frame_slot !== want.frame_slot)
            flag_mismatch("frame_slot", 64'(got.frame_slot), 64'(want.frame_slot));
          if (got.evicted_valid !== want.evicted_valid)
            flag_mismatch("evicted_valid", 64'(got.evicted_valid), 64'(want.evicted_valid));
          if (got.evicted_page !== want.evicted_page)
            flag_mismatch("evicted_page", 64'(got.evicted_page), 64'(want.evicted_page));
          if (got.fault_total !== want.fault_total)
            flag_mismatch("fault_total", 64'(got.fault_total), 64'(want.fault_total));
          if (got.reference_total !== want.reference_total)
            flag_mismatch("reference_total", 64'(got.reference_total),
                          64'(want.reference_total));
        end
      end
      if (s_tvalid && s_tready) begin
        resolve_reference(s_tdata[PAGE_W-1:0], want);
        result_queue.push_back(want);
      end
      if (psel && penable && pready && paddr == ADDR_FRAMES_IN_USE) begin
        if (pwrite)
          frames_cfg = pwdata[CFG_W-1:0];
        else if (prdata !== 32'(frames_cfg))
          flag_mismatch("frames_in_use readback", 64'(prdata), 64'(frames_cfg));
      end
    end
    outstanding <= result_queue.size();
  end

endmodule

### bench/tb_lfu_page_replacement.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_lfu_page_replacement
// drives page references and frames_in_use settings into the lfu frame table,
// with random idling on both streams; lfu_checker predicts and compares
// ---------------------------------------------------------------------------
module tb_lfu_page_replacement;
  import lfu_pkg::*;

  localparam logic [ADDR_W-1:0] ADDR_UNMAPPED = 3'd4;
  localparam int POOL = 96;
  localparam int ITEMS_PER_PHASE = 138;
  localparam int SETTLE_CYCLES = 70;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [87:0] m_tdata;
  logic        m_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int errors;
  int outstanding;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_len = 0;
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_left = 0;

  int phase_frames [12] = '{64, 1, 8, 3, 127, 0, 16, 5, 2, 40, 64, 7};
  logic [15:0] page_pool [POOL];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  lfu_page_replacement dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  lfu_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .errors(errors), .outstanding(outstanding)
  );

  // result side: random stalls, plus a long hold-off when the stimulus asks for one
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_page(input logic [15:0] page);
    int idle;
    idle = 0;
    while (idle < 40 && $urandom_range(99) < send_idle_pct) idle++;
    if (idle > 0) begin
      s_tvalid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= page;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // stop sending and wait until every result has come back and the block is quiet
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
    settle();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic read_reg(input logic [ADDR_W-1:0] addr);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    #40_000_000;
    $display("lfu_page_replacement test failed");
    $finish;
  end

  initial begin
    int          active;
    int          pool_size;
    int          pick;
    logic [15:0] page;
    logic [31:0] word;
    for (int i = 0; i < POOL; i++) page_pool[i] = 16'($urandom());
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset setting, page extremes, hits, clamped settings, unmapped write
    read_reg(ADDR_FRAMES_IN_USE);
    send_page(16'h0000);
    send_page(16'hFFFF);
    send_page(16'h0000);
    send_page(16'hFFFF);
    send_page(16'h5555);
    send_page(16'hAAAA);
    send_page(16'h0000);
    // zero acts as a single frame; frames above it keep their pages
    write_reg(ADDR_FRAMES_IN_USE, 32'd0);
    read_reg(ADDR_FRAMES_IN_USE);
    send_page(16'h0001);
    send_page(16'hFFFF);
    send_page(16'hFFFF);
    write_reg(ADDR_FRAMES_IN_USE, 32'd3);
    send_page(16'h5555);
    send_page(16'h1234);
    // above the frame count clamps to all frames
    write_reg(ADDR_FRAMES_IN_USE, 32'hFFFF_FF7F);
    send_page(16'hAAAA);
    send_page(16'hFFFF);
    write_reg(ADDR_UNMAPPED, 32'd1);
    read_reg(ADDR_FRAMES_IN_USE);
    send_page(16'h7777);
    send_page(16'h8000);

    // use counts: the heavily used frame survives while the other one turns over
    write_reg(ADDR_FRAMES_IN_USE, 32'd2);
    send_page(16'hBEEF);
    repeat (20) send_page(16'hBEEF);
    send_page(16'h0F0F);
    repeat (10) send_page(16'h0F0F);
    send_page(16'hF0F0);
    send_page(16'hBEEF);

    // random phases: skewed picks from a shared page pool, some noise pages
    for (int ph = 0; ph < 12; ph++) begin
      word = ($urandom() & ~32'h7F) | 32'(phase_frames[ph]);
      write_reg(ADDR_FRAMES_IN_USE, word);
      read_reg(ADDR_FRAMES_IN_USE);
      active = phase_frames[ph];
      if (active == 0) active = 1;
      if (active > 64) active = 64;
      pool_size = active + active / 2 + 2;
      if (pool_size > POOL) pool_size = POOL;
      case (ph % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 52;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 52;
        end
        default: begin
          send_idle_pct = 33;
          recv_stall_pct = 33;
        end
      endcase
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (ph == 4 && k == 40) begin
          hold_len = 400;
          hold_seq++;
        end
        if (ph == 6 && k == 70) settle();
        pick = $urandom_range(99);
        if (pick < 8)
          page = 16'($urandom());
        else if (pick < 50)
          page = page_pool[$urandom_range((pool_size - 1) / 4, 0)];
        else
          page = page_pool[$urandom_range(pool_size - 1, 0)];
        send_page(page);
      end
    end

    send_idle_pct = 0;
    settle();
    if (errors == 0 && outstanding == 0) begin
      $display("lfu_page_replacement test passed");
    end else begin
      $display("lfu_page_replacement test failed");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/lfu_pkg.sv
hw/rtl/lfu_ram.sv
hw/rtl/lfu_ctrl.sv
hw/rtl/lfu_datapath.sv
hw/rtl/lfu_page_replacement.sv
bench/lfu_checker.sv
bench/tb_lfu_page_replacement.sv
